@@ rtl/mse_pkg.sv @@
`default_nettype none
package mse_pkg;

  // Command codes
  localparam logic [5:0] CMD_ADD     = 6'd0;
  localparam logic [5:0] CMD_ADDU    = 6'd1;
  localparam logic [5:0] CMD_SUB     = 6'd2;
  localparam logic [5:0] CMD_AND     = 6'd3;
  localparam logic [5:0] CMD_OR      = 6'd4;
  localparam logic [5:0] CMD_XOR     = 6'd5;
  localparam logic [5:0] CMD_NOR     = 6'd6;
  localparam logic [5:0] CMD_NAND    = 6'd7;
  localparam logic [5:0] CMD_SLT     = 6'd8;
  localparam logic [5:0] CMD_SLL     = 6'd9;
  localparam logic [5:0] CMD_SRL     = 6'd10;
  localparam logic [5:0] CMD_SRA     = 6'd11;
  localparam logic [5:0] CMD_JR      = 6'd12;
  localparam logic [5:0] CMD_ADDI    = 6'd13;
  localparam logic [5:0] CMD_ADDIU   = 6'd14;
  localparam logic [5:0] CMD_LW      = 6'd15;
  localparam logic [5:0] CMD_LH      = 6'd16;
  localparam logic [5:0] CMD_LHU     = 6'd17;
  localparam logic [5:0] CMD_LB      = 6'd18;
  localparam logic [5:0] CMD_LBU     = 6'd19;
  localparam logic [5:0] CMD_SW      = 6'd20;
  localparam logic [5:0] CMD_SH      = 6'd21;
  localparam logic [5:0] CMD_SB      = 6'd22;
  localparam logic [5:0] CMD_LUI     = 6'd23;
  localparam logic [5:0] CMD_ANDI    = 6'd24;
  localparam logic [5:0] CMD_ORI     = 6'd25;
  localparam logic [5:0] CMD_NORI    = 6'd26;
  localparam logic [5:0] CMD_SLTI    = 6'd27;
  localparam logic [5:0] CMD_BEQ     = 6'd28;
  localparam logic [5:0] CMD_BNE     = 6'd29;
  localparam logic [5:0] CMD_BGTZ    = 6'd30;
  localparam logic [5:0] CMD_J       = 6'd31;
  localparam logic [5:0] CMD_HALT    = 6'd32;
  localparam logic [5:0] CMD_PRELOAD = 6'd33;
  localparam logic [5:0] CMD_JAL     = 6'd34;

  // Configuration register indexes
  localparam logic [0:0] CFG_START_PC      = 1'b0;
  localparam logic [0:0] CFG_STACK_POINTER = 1'b1;

  localparam logic [4:0]  REG_ZERO = 5'd0;
  localparam logic [4:0]  REG_SP   = 5'd29;
  localparam logic [4:0]  REG_RA   = 5'd31;
  localparam logic [31:0] PC_STEP  = 32'd4;

  typedef enum logic [1:0] {
    SZ_BYTE,
    SZ_HALF,
    SZ_WORD
  } size_e;

  typedef struct packed {
    logic [5:0]  command;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [25:0] immediate;
    logic [7:0]  preload_index;
    logic [31:0] preload_value;
    logic        is_mem;
    size_e       size;
  } instr_t;

  typedef struct packed {
    logic   valid;
    instr_t instr;
  } queue_head_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic        zero_write_error;
    logic        number_overflow;
    logic        address_overflow;
    logic        misaligned;
    logic        halted;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/mse_in_if.sv @@
`default_nettype none
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  command;
  logic [4:0]  src_reg;
  logic [4:0]  tgt_reg;
  logic [4:0]  dst_reg;
  logic [25:0] immediate;
  logic [7:0]  preload_index;
  logic [31:0] preload_value;

  modport source (
    output valid, command, src_reg, tgt_reg, dst_reg, immediate, preload_index,
           preload_value,
    input  ready
  );
  modport sink (
    input  valid, command, src_reg, tgt_reg, dst_reg, immediate, preload_index,
           preload_value,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/mse_out_if.sv @@
`default_nettype none
interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  written_reg;
  logic [31:0] written_value;
  logic        zero_write_error;
  logic        number_overflow;
  logic        address_overflow;
  logic        misaligned;
  logic        halted;

  modport source (
    output valid, next_pc, reg_written, written_reg, written_value, zero_write_error,
           number_overflow, address_overflow, misaligned, halted,
    input  ready
  );
  modport sink (
    input  valid, next_pc, reg_written, written_reg, written_value, zero_write_error,
           number_overflow, address_overflow, misaligned, halted,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/mse_front.sv @@
`default_nettype none
module mse_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mse_in_if.sink               in_if,
  input  logic                 deq_i,
  output mse_pkg::queue_head_t head_o
);
  import mse_pkg::*;

  instr_t     dec;
  instr_t     ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  // classify the command
  always_comb begin
    dec.command       = in_if.command;
    dec.src_reg       = in_if.src_reg;
    dec.tgt_reg       = in_if.tgt_reg;
    dec.dst_reg       = in_if.dst_reg;
    dec.immediate     = in_if.immediate;
    dec.preload_index = in_if.preload_index;
    dec.preload_value = in_if.preload_value;
    dec.is_mem        = (in_if.command >= CMD_LW) && (in_if.command <= CMD_SB);
    unique if (in_if.command == CMD_LW || in_if.command == CMD_SW) begin
      dec.size = SZ_WORD;
    end else if (in_if.command == CMD_LB || in_if.command == CMD_LBU ||
                 in_if.command == CMD_SB) begin
      dec.size = SZ_BYTE;
    end else begin
      dec.size = SZ_HALF;
    end
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (deq_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, deq_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= dec;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.instr = ent_q[rd_ptr_q];

endmodule
`default_nettype wire

@@ rtl/mse_back.sv @@
`default_nettype none
module mse_back #(
  parameter int unsigned DATA_WORDS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mse_pkg::queue_head_t head_i,
  output logic                 deq_o,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  mse_out_if.source            out_if
);
  import mse_pkg::*;

  localparam int unsigned IDX_W     = $clog2(DATA_WORDS);
  localparam logic [32:0] MEM_BYTES = 33'(DATA_WORDS * 4);
  localparam logic [31:0] WORDS_32  = 32'(DATA_WORDS);

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_q;
  logic [31:0] dm_mem [DATA_WORDS];

  logic        ex_valid_q, phase_q, stopped_q;
  instr_t      ex_q;
  logic [31:0] pc_q;
  logic [31:0] a_mem_q, b_mem_q, fwd_val_q;
  logic        a_ok_q, b_ok_q, a_fwd_q, b_fwd_q;
  logic [31:0] addr_q, dm_rdata_q;
  logic        ovf_q, aovf_q, mis_q;
  logic        out_valid_q;
  result_t     out_q;

  logic [31:0] a, b, se, addr_c, pc4, br_pc, j_pc;
  logic [15:0] i16;
  logic [4:0]  sh, bs;
  logic [32:0] nbytes;
  logic        aovf_c, mis_c, ovf_addr_c;
  logic        needs_two, final_phase, ex_done, issue, out_free;

  logic [31:0] val, next_c, st_data, sh_word, by_word;
  logic [4:0]  tgt;
  logic        has_tgt, nop, ovf, halt, fatal, wr;
  result_t     res;
  logic        rf_we;
  logic [4:0]  rf_wreg;
  logic [31:0] rf_wval;
  logic        dm_we, dm_re;
  logic [IDX_W-1:0] dm_widx, dm_ridx;
  logic [31:0] dm_wdata, pidx32;
  logic        stop_c;

  assign a = a_fwd_q ? fwd_val_q : (a_ok_q ? a_mem_q : '0);
  assign b = b_fwd_q ? fwd_val_q : (b_ok_q ? b_mem_q : '0);

  assign i16    = ex_q.immediate[15:0];
  assign se     = {{16{i16[15]}}, i16};
  assign sh     = ex_q.immediate[4:0];
  assign addr_c = a + se;
  assign ovf_addr_c = (~(a[31] ^ se[31])) & (a[31] ^ addr_c[31]);
  assign pc4    = pc_q + PC_STEP;
  assign br_pc  = pc4 + {se[29:0], 2'b00};
  assign j_pc   = {pc4[31:28], ex_q.immediate, 2'b00};
  assign bs     = {~addr_q[1:0], 3'b000};

  always_comb begin
    unique case (ex_q.size)
      SZ_BYTE: nbytes = 33'd1;
      SZ_HALF: nbytes = 33'd2;
      SZ_WORD: nbytes = 33'd4;
      default: nbytes = 33'd4;
    endcase
  end

  assign aovf_c = {1'b0, addr_c} > (MEM_BYTES - nbytes);
  assign mis_c  = (ex_q.size == SZ_HALF && addr_c[0]) ||
                  (ex_q.size == SZ_WORD && addr_c[1:0] != 2'b00);

  // memory ops take an address phase and an access phase until the block has stopped
  assign needs_two   = ex_q.is_mem && !stopped_q;
  assign final_phase = !needs_two || phase_q;
  assign out_free    = !out_valid_q || out_if.ready;
  assign ex_done     = ex_valid_q && final_phase && out_free;
  assign issue       = head_i.valid && (!ex_valid_q || ex_done);
  assign deq_o       = issue;

  assign sh_word = addr_q[1] ? {dm_rdata_q[31:16], b[15:0]} : {b[15:0], dm_rdata_q[15:0]};
  assign by_word = (dm_rdata_q & ~(32'h0000_00ff << bs)) | ({24'd0, b[7:0]} << bs);

  always_comb begin
    val     = '0;
    tgt     = ex_q.dst_reg;
    has_tgt = 1'b0;
    nop     = 1'b0;
    ovf     = 1'b0;
    halt    = 1'b0;
    next_c  = pc4;
    st_data = b;
    unique case (ex_q.command)
      CMD_ADD: begin
        val = a + b; has_tgt = 1'b1;
        ovf = (~(a[31] ^ b[31])) & (a[31] ^ val[31]);
      end
      CMD_ADDU: begin val = a + b; has_tgt = 1'b1; end
      CMD_SUB: begin
        val = a - b; has_tgt = 1'b1;
        ovf = (a[31] ^ b[31]) & (a[31] ^ val[31]);
      end
      CMD_AND:  begin val = a & b; has_tgt = 1'b1; end
      CMD_OR:   begin val = a | b; has_tgt = 1'b1; end
      CMD_XOR:  begin val = a ^ b; has_tgt = 1'b1; end
      CMD_NOR:  begin val = ~(a | b); has_tgt = 1'b1; end
      CMD_NAND: begin val = ~(a & b); has_tgt = 1'b1; end
      CMD_SLT:  begin val = {31'd0, $signed(a) < $signed(b)}; has_tgt = 1'b1; end
      CMD_SLL: begin
        val = b << sh; has_tgt = 1'b1;
        nop = (ex_q.dst_reg == REG_ZERO) && (ex_q.tgt_reg == REG_ZERO) && (sh == 5'd0);
      end
      CMD_SRL: begin val = b >> sh; has_tgt = 1'b1; end
      CMD_SRA: begin val = $unsigned($signed(b) >>> sh); has_tgt = 1'b1; end
      CMD_JR:  next_c = a;
      CMD_ADDI: begin
        val = a + se; has_tgt = 1'b1; tgt = ex_q.tgt_reg;
        ovf = ovf_addr_c;
      end
      CMD_ADDIU: begin val = a + se; has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_LW: begin val = dm_rdata_q; has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_LH: begin
        val = addr_q[1] ? {{16{dm_rdata_q[15]}}, dm_rdata_q[15:0]}
                        : {{16{dm_rdata_q[31]}}, dm_rdata_q[31:16]};
        has_tgt = 1'b1; tgt = ex_q.tgt_reg;
      end
      CMD_LHU: begin
        val = addr_q[1] ? {16'd0, dm_rdata_q[15:0]} : {16'd0, dm_rdata_q[31:16]};
        has_tgt = 1'b1; tgt = ex_q.tgt_reg;
      end
      CMD_LB: begin
        val = dm_rdata_q >> bs;
        val = {{24{val[7]}}, val[7:0]};
        has_tgt = 1'b1; tgt = ex_q.tgt_reg;
      end
      CMD_LBU: begin
        val = dm_rdata_q >> bs;
        val = {24'd0, val[7:0]};
        has_tgt = 1'b1; tgt = ex_q.tgt_reg;
      end
      CMD_SW: st_data = b;
      CMD_SH: st_data = sh_word;
      CMD_SB: st_data = by_word;
      CMD_LUI:  begin val = {i16, 16'd0}; has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_ANDI: begin val = a & {16'd0, i16}; has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_ORI:  begin val = a | {16'd0, i16}; has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_NORI: begin val = ~(a | {16'd0, i16}); has_tgt = 1'b1; tgt = ex_q.tgt_reg; end
      CMD_SLTI: begin
        val = {31'd0, $signed(a) < $signed(se)}; has_tgt = 1'b1; tgt = ex_q.tgt_reg;
      end
      CMD_BEQ:  if (a == b) next_c = br_pc;
      CMD_BNE:  if (a != b) next_c = br_pc;
      CMD_BGTZ: if (a != '0 && !a[31]) next_c = br_pc;
      CMD_J:    next_c = j_pc;
      CMD_HALT: halt = 1'b1;
      CMD_PRELOAD: next_c = pc_q;
      CMD_JAL: begin val = pc4; has_tgt = 1'b1; tgt = REG_RA; next_c = j_pc; end
      default: ;
    endcase
    if (ex_q.is_mem) ovf = ovf_q;
  end

  assign fatal  = ex_q.is_mem && (aovf_q || mis_q);
  assign wr     = has_tgt && (tgt != REG_ZERO) && !fatal;
  assign stop_c = fatal || halt;
  assign pidx32 = 32'(ex_q.preload_index);

  always_comb begin
    res = '0;
    if (stopped_q) begin
      res.next_pc = pc_q;
      res.halted  = 1'b1;
    end else begin
      res.next_pc          = stop_c ? pc_q : next_c;
      res.reg_written      = wr;
      res.written_reg      = wr ? tgt : '0;
      res.written_value    = wr ? val : '0;
      res.zero_write_error = has_tgt && (tgt == REG_ZERO) && !nop;
      res.number_overflow  = ovf;
      res.address_overflow = ex_q.is_mem && aovf_q;
      res.misaligned       = ex_q.is_mem && mis_q;
      res.halted           = stop_c;
    end
  end

  // register file write port: configuration or retiring instruction
  always_comb begin
    if (cfg_we_i && cfg_idx_i == CFG_STACK_POINTER) begin
      rf_we   = 1'b1;
      rf_wreg = REG_SP;
      rf_wval = cfg_data_i;
    end else begin
      rf_we   = ex_done && !stopped_q && wr;
      rf_wreg = tgt;
      rf_wval = val;
    end
  end

  // data memory write port: preload or store
  always_comb begin
    dm_we    = 1'b0;
    dm_widx  = addr_q[IDX_W+1:2];
    dm_wdata = st_data;
    if (ex_done && !stopped_q) begin
      if (ex_q.command == CMD_PRELOAD) begin
        dm_we    = pidx32 < WORDS_32;
        dm_widx  = pidx32[IDX_W-1:0];
        dm_wdata = ex_q.preload_value;
      end else if (ex_q.command == CMD_SW || ex_q.command == CMD_SH ||
                   ex_q.command == CMD_SB) begin
        dm_we = !fatal;
      end
    end
  end

  assign dm_re   = ex_valid_q && needs_two && !phase_q && !aovf_c && !mis_c;
  assign dm_ridx = addr_c[IDX_W+1:2];

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wreg] <= rf_wval;
    if (issue) begin
      a_mem_q <= rf_mem[head_i.instr.src_reg];
      b_mem_q <= rf_mem[head_i.instr.tgt_reg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_widx] <= dm_wdata;
    if (dm_re) dm_rdata_q <= dm_mem[dm_ridx];
  end

  // operand capture with write-first bypass, address-cycle results
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_q      <= head_i.instr;
      a_ok_q    <= rf_valid_q[head_i.instr.src_reg];
      b_ok_q    <= rf_valid_q[head_i.instr.tgt_reg];
      a_fwd_q   <= rf_we && (rf_wreg == head_i.instr.src_reg);
      b_fwd_q   <= rf_we && (rf_wreg == head_i.instr.tgt_reg);
      fwd_val_q <= rf_wval;
    end
    if (ex_valid_q && needs_two && !phase_q) begin
      addr_q <= addr_c;
      ovf_q  <= ovf_addr_c;
      aovf_q <= aovf_c;
      mis_q  <= mis_c;
    end
    if (ex_done) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q  <= '0;
      ex_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      stopped_q   <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rf_we) rf_valid_q[rf_wreg] <= 1'b1;
      if (issue) begin
        ex_valid_q <= 1'b1;
      end else if (ex_done) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_done) begin
        phase_q <= 1'b0;
      end else if (ex_valid_q && needs_two) begin
        phase_q <= 1'b1;
      end
      if (cfg_we_i && cfg_idx_i == CFG_START_PC) begin
        pc_q <= cfg_data_i;
      end else if (ex_done && !stopped_q) begin
        pc_q <= res.next_pc;
      end
      if (ex_done && !stopped_q && stop_c) stopped_q <= 1'b1;
      if (ex_done) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.next_pc          = out_q.next_pc;
  assign out_if.reg_written      = out_q.reg_written;
  assign out_if.written_reg      = out_q.written_reg;
  assign out_if.written_value    = out_q.written_value;
  assign out_if.zero_write_error = out_q.zero_write_error;
  assign out_if.number_overflow  = out_q.number_overflow;
  assign out_if.address_overflow = out_q.address_overflow;
  assign out_if.misaligned       = out_q.misaligned;
  assign out_if.halted           = out_q.halted;

endmodule
`default_nettype wire

@@ rtl/mips_subset_execute_unit_top.sv @@
`default_nettype none
// Execute unit for a decoded MIPS-like integer subset (with nand and nori). Each input
// transaction is one instruction, a halt or a data preload; each produces exactly one
// result transaction with the next PC, the register write and the error flags. A front
// stage accepts and classifies commands into a two-entry queue; the back stage reads the
// 32-entry register file (registered read with write-first bypass), executes, and holds
// the result in an output register so input can keep flowing while a result waits.
// Register-to-register, branch, jump, halt and preload commands retire one per cycle
// while the queue holds a command and the output register is free; loads and stores
// take an address step, then the access and write-back, set by the registered read
// port of the data memory, and skip the address step once the block has stopped. The
// data memory holds DATA_WORDS big-endian 32-bit words and is undefined until
// preloaded or stored. Write start_pc and stack_pointer only while idle; each write
// takes effect at once. After a halt or a fatal access every further command reports
// halted and changes nothing.
module mips_subset_execute_unit_top #(
  parameter int unsigned DATA_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mse_in_if.sink      in_i,
  mse_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import mse_pkg::*;

  queue_head_t head;
  logic        deq;

  // accept and classify, buffer two transactions
  mse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_i),
    .deq_i  (deq),
    .head_o (head)
  );

  // operand read, execute, memory access, result register
  mse_back #(
    .DATA_WORDS (DATA_WORDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .deq_o      (deq),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_if     (out_o)
  );

`ifndef SYNTHESIS
  // pop only from a non-empty queue
  a_deq_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> head.valid) else $error("dequeue from empty queue");

  // register zero is never reported as written
  a_no_zero_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.reg_written |-> out_o.written_reg != REG_ZERO)
    else $error("write to register zero reported");

  // a fatal access halts and suppresses the register write
  a_fatal_halts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.address_overflow || out_o.misaligned)
      |-> out_o.halted && !out_o.reg_written)
    else $error("fatal access did not halt");
`endif

endmodule
`default_nettype wire
